// File: src/mjp_pkg.sv
// Package for the manifest parser: phase, error, event and status codes, field name table.
`default_nettype none
package mjp_pkg;

  localparam int unsigned FieldCount = 17;

  typedef enum logic [3:0] {
    PH_BEFORE_OPEN  = 4'd0,
    PH_AFTER_OPEN   = 4'd1,
    PH_IN_KEY       = 4'd2,
    PH_KEY_ESC      = 4'd3,
    PH_AFTER_KEY    = 4'd4,
    PH_BEFORE_VALUE = 4'd5,
    PH_NUM_ZERO     = 4'd6,
    PH_NUM_DIGITS   = 4'd7,
    PH_IN_STR       = 4'd8,
    PH_STR_ESC      = 4'd9,
    PH_AFTER_VALUE  = 4'd10,
    PH_AFTER_COMMA  = 4'd11,
    PH_AFTER_CLOSE  = 4'd12,
    PH_FAILED       = 4'd13
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NOT_OBJECT = 4'd1,
    ERR_BAD_KEY    = 4'd2,
    ERR_UNKNOWN    = 4'd3,
    ERR_DUPLICATE  = 4'd4,
    ERR_NO_COLON   = 4'd5,
    ERR_BAD_NUMBER = 4'd6,
    ERR_BAD_STRING = 4'd7,
    ERR_TRAIL_COMMA = 4'd8,
    ERR_INCOMPLETE = 4'd9,
    ERR_TRAIL_DATA = 4'd10,
    ERR_MISSING    = 4'd11
  } err_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_STR_BYTE = 2'd1,
    EV_STR_DONE = 2'd2,
    EV_NUM_DONE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  // Names padded with zero bytes; the zero terminator never matches a key byte,
  // because key bytes below 0x20 are rejected or come from escapes that are nonzero.
  function automatic logic [7:0] name_char(input logic [4:0] f, input logic [4:0] ofs);
    logic [21*8-1:0] s;
    logic [7:0] c;
    s = '0;
    case (f)
      5'd0:  s = {"schema", {15{8'h00}}};
      5'd1:  s = {"product", {14{8'h00}}};
      5'd2:  s = {"channel", {14{8'h00}}};
      5'd3:  s = {"target", {15{8'h00}}};
      5'd4:  s = {"partitionScheme", {6{8'h00}}};
      5'd5:  s = {"name", {17{8'h00}}};
      5'd6:  s = {"version", {14{8'h00}}};
      5'd7:  s = {"versionCode", {10{8'h00}}};
      5'd8:  s = "minUpdaterVersionCode";
      5'd9:  s = {"releaseType", {10{8'h00}}};
      5'd10: s = {"description", {10{8'h00}}};
      5'd11: s = {"publishedAt", {10{8'h00}}};
      5'd12: s = {"firmware", {13{8'h00}}};
      5'd13: s = {"size", {17{8'h00}}};
      5'd14: s = {"sha256", {15{8'h00}}};
      5'd15: s = {"keyId", {16{8'h00}}};
      5'd16: s = {"signature", {12{8'h00}}};
      default: s = '0;
    endcase
    if (ofs < 5'd21) c = s[(20 - ofs) * 8 +: 8];
    else c = 8'h00;
    return c;
  endfunction

  function automatic logic [4:0] name_len(input logic [4:0] f);
    logic [4:0] l;
    case (f)
      5'd0: l = 5'd6;   5'd1: l = 5'd7;   5'd2: l = 5'd7;   5'd3: l = 5'd6;
      5'd4: l = 5'd15;  5'd5: l = 5'd4;   5'd6: l = 5'd7;   5'd7: l = 5'd11;
      5'd8: l = 5'd21;  5'd9: l = 5'd11;  5'd10: l = 5'd11; 5'd11: l = 5'd11;
      5'd12: l = 5'd8;  5'd13: l = 5'd4;  5'd14: l = 5'd6;  5'd15: l = 5'd5;
      5'd16: l = 5'd9;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_numeric(input logic [4:0] f);
    return (f == 5'd0) || (f == 5'd7) || (f == 5'd8) || (f == 5'd13);
  endfunction

endpackage
`default_nettype wire

// File: src/mjp_if.sv
// Valid/ready channel interfaces for the manifest parser input and result items.
`default_nettype none
interface mjp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface mjp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  value_event;
  logic [4:0]  field_index;
  logic [7:0]  value_char;
  logic [31:0] number_value;
  logic [1:0]  parse_status;
  logic [3:0]  error_code;
  modport source (output valid, value_event, field_index, value_char, number_value,
                  parse_status, error_code, input ready);
  modport sink (input valid, value_event, field_index, value_char, number_value,
                parse_status, error_code, output ready);
endinterface
`default_nettype wire

// File: src/manifest_json_parser.sv
// Top level of the streaming manifest parser: one byte in, one result item out.
//
//   channel  | dir | payload
//   in_ch    | in  | text_byte, end_of_text
//   out_ch   | out | value_event, field_index, value_char, number_value,
//            |     | parse_status, error_code
//
// Each byte yields one result item, registered and presented in the cycle after the byte is taken.
// A byte is taken whenever the result register is empty or being emptied, so the
// sustained rate is one byte a cycle while the output does not stall, set by the single result register.
// Reset returns the parser to the state before the opening brace with no result held.
// A stall on the output holds the result and the parser state.
`default_nettype none
module manifest_json_parser
  import mjp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mjp_in_if.sink     in_ch,
  mjp_out_if.source  out_ch
);

  phase_e      phase_q, phase_d;
  logic [16:0] seen_q, seen_d;
  logic [16:0] cand_q, cand_d;
  logic [4:0]  kofs_q, kofs_d;
  logic [4:0]  field_q, field_d;
  logic [31:0] acc_q, acc_d;
  err_e        err_q, err_d;

  logic        ovalid_q;
  event_e      ev_q, ev_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [7:0]  ch_q, ch_d;
  logic [31:0] num_q, num_d;
  status_e     st_q, st_d;
  err_e        oerr_q;

  logic        take;
  logic [7:0]  c;
  logic        last;
  logic        ws, dig;
  logic [7:0]  dec;
  logic        dec_ok;
  logic [35:0] mul;
  logic [4:0]  found;
  logic        found_ok;
  logic [3:0]  endc;

  assign in_ch.ready = !ovalid_q || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign c = in_ch.text_byte;
  assign last = in_ch.end_of_text;
  assign ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  assign dig = (c >= "0") && (c <= "9");
  assign mul = {4'd0, acc_q} * 36'd10 + {28'd0, c - 8'h30};

  always_comb begin
    dec_ok = 1'b1;
    case (c)
      "\"", "\\", "/": dec = c;
      "b": dec = 8'h08;
      "f": dec = 8'h0C;
      "n": dec = 8'h0A;
      "r": dec = 8'h0D;
      "t": dec = 8'h09;
      default: begin
        dec = 8'h00;
        dec_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    found = 5'd0;
    found_ok = 1'b0;
    for (int i = 0; i < FieldCount; i++) begin
      if (cand_q[i] && name_len(5'(i)) == kofs_q) begin
        found = 5'(i);
        found_ok = 1'b1;
      end
    end
  end

  always_comb begin
    logic       kc;
    logic [7:0] kb;
    logic [4:0] fe;
    kc = 1'b0;
    kb = c;
    fe = 5'd0;
    phase_d = phase_q;
    seen_d = seen_q;
    cand_d = cand_q;
    kofs_d = kofs_q;
    field_d = field_q;
    acc_d = acc_q;
    err_d = err_q;
    ev_d = EV_NONE;
    ch_d = 8'h00;
    num_d = 32'd0;
    endc = 4'd0;
    if (err_q == ERR_NONE) begin
      case (phase_q)
        PH_BEFORE_OPEN:
          if (!ws) begin
            if (c == "{") phase_d = PH_AFTER_OPEN;
            else fe = {1'b1, ERR_NOT_OBJECT};
          end
        PH_AFTER_OPEN, PH_AFTER_COMMA:
          if (!ws) begin
            if (c == "}") begin
              if (phase_q == PH_AFTER_OPEN) phase_d = PH_AFTER_CLOSE;
              else fe = {1'b1, ERR_TRAIL_COMMA};
            end else if (c == "\"") begin
              cand_d = '1;
              kofs_d = 5'd0;
              phase_d = PH_IN_KEY;
            end else fe = {1'b1, ERR_BAD_KEY};
          end
        PH_IN_KEY:
          if (c == "\"") begin
            if (!found_ok) fe = {1'b1, ERR_UNKNOWN};
            else if (seen_q[found]) fe = {1'b1, ERR_DUPLICATE};
            else begin
              seen_d = seen_q | (17'd1 << found);
              field_d = found;
              phase_d = PH_AFTER_KEY;
            end
          end else if (c < 8'h20) fe = {1'b1, ERR_BAD_KEY};
          else if (c == "\\") phase_d = PH_KEY_ESC;
          else kc = 1'b1;
        PH_KEY_ESC:
          if (dec_ok) begin
            kc = 1'b1;
            kb = dec;
            phase_d = PH_IN_KEY;
          end else fe = {1'b1, ERR_BAD_KEY};
        PH_AFTER_KEY:
          if (!ws) begin
            if (c == ":") phase_d = PH_BEFORE_VALUE;
            else fe = {1'b1, ERR_NO_COLON};
          end
        PH_BEFORE_VALUE:
          if (!ws) begin
            if (is_numeric(field_q)) begin
              if (dig) begin
                acc_d = {24'd0, c - 8'h30};
                phase_d = (c == "0") ? PH_NUM_ZERO : PH_NUM_DIGITS;
              end else fe = {1'b1, ERR_BAD_NUMBER};
            end else begin
              if (c == "\"") phase_d = PH_IN_STR;
              else fe = {1'b1, ERR_BAD_STRING};
            end
          end
        PH_NUM_ZERO, PH_NUM_DIGITS:
          if (dig) begin
            if (phase_q == PH_NUM_ZERO || mul[35:32] != 4'd0) fe = {1'b1, ERR_BAD_NUMBER};
            else acc_d = mul[31:0];
          end else begin
            ev_d = EV_NUM_DONE;
            num_d = acc_q;
            phase_d = PH_AFTER_VALUE;
            if (!ws) begin
              if (c == ",") phase_d = PH_AFTER_COMMA;
              else if (c == "}") phase_d = PH_AFTER_CLOSE;
              else fe = {1'b1, ERR_INCOMPLETE};
            end
          end
        PH_IN_STR:
          if (c == "\"") begin
            ev_d = EV_STR_DONE;
            phase_d = PH_AFTER_VALUE;
          end else if (c < 8'h20) fe = {1'b1, ERR_BAD_STRING};
          else if (c == "\\") phase_d = PH_STR_ESC;
          else begin
            ev_d = EV_STR_BYTE;
            ch_d = c;
          end
        PH_STR_ESC:
          if (dec_ok) begin
            ev_d = EV_STR_BYTE;
            ch_d = dec;
            phase_d = PH_IN_STR;
          end else fe = {1'b1, ERR_BAD_STRING};
        PH_AFTER_VALUE:
          if (!ws) begin
            if (c == ",") phase_d = PH_AFTER_COMMA;
            else if (c == "}") phase_d = PH_AFTER_CLOSE;
            else fe = {1'b1, ERR_INCOMPLETE};
          end
        PH_AFTER_CLOSE:
          if (!ws) fe = {1'b1, ERR_TRAIL_DATA};
        default: fe = {1'b1, ERR_INCOMPLETE};
      endcase
      if (kc) begin
        for (int i = 0; i < FieldCount; i++) begin
          if (kofs_q >= name_len(5'(i)) || name_char(5'(i), kofs_q) != kb)
            cand_d[i] = 1'b0;
        end
        if (kofs_q != 5'd31) kofs_d = kofs_q + 5'd1;
      end
      if (fe[4]) begin
        err_d = err_e'(fe[3:0]);
        phase_d = PH_FAILED;
      end
    end
    // End checks run on the phase reached after this byte.
    if (last && err_d == ERR_NONE) begin
      case (phase_d)
        PH_BEFORE_OPEN: endc = ERR_NOT_OBJECT;
        PH_IN_KEY, PH_KEY_ESC: endc = ERR_BAD_KEY;
        PH_AFTER_KEY: endc = ERR_NO_COLON;
        PH_BEFORE_VALUE: endc = is_numeric(field_d) ? ERR_BAD_NUMBER : ERR_BAD_STRING;
        PH_IN_STR, PH_STR_ESC: endc = ERR_BAD_STRING;
        PH_AFTER_CLOSE: endc = (seen_d == '1) ? ERR_NONE : ERR_MISSING;
        default: endc = ERR_INCOMPLETE;
      endcase
      err_d = err_e'(endc);
    end
    fidx_d = (ev_d != EV_NONE) ? field_q : 5'd0;
    if (err_d != ERR_NONE) st_d = ST_REJECTED;
    else if (last) st_d = ST_ACCEPTED;
    else st_d = ST_RUNNING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEFORE_OPEN;
      seen_q <= '0;
      cand_q <= '1;
      kofs_q <= '0;
      field_q <= '0;
      acc_q <= '0;
      err_q <= ERR_NONE;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        ovalid_q <= 1'b1;
        if (last) begin
          phase_q <= PH_BEFORE_OPEN;
          seen_q <= '0;
          cand_q <= '1;
          kofs_q <= '0;
          field_q <= '0;
          acc_q <= '0;
          err_q <= ERR_NONE;
        end else begin
          phase_q <= phase_d;
          seen_q <= seen_d;
          cand_q <= cand_d;
          kofs_q <= kofs_d;
          field_q <= field_d;
          acc_q <= acc_d;
          err_q <= err_d;
        end
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q <= ev_d;
      fidx_q <= fidx_d;
      ch_q <= ch_d;
      num_q <= num_d;
      st_q <= st_d;
      oerr_q <= err_d;
    end
  end

  assign out_ch.valid = ovalid_q;
  assign out_ch.value_event = ev_q;
  assign out_ch.field_index = fidx_q;
  assign out_ch.value_char = ch_q;
  assign out_ch.number_value = num_q;
  assign out_ch.parse_status = st_q;
  assign out_ch.error_code = oerr_q;

  // A latched error always goes with the failed phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |-> (phase_q == PH_FAILED))
    else $error("error latched without failed phase");

  // A rejected result always carries a nonzero code, and only rejected ones do.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> ((st_q == ST_REJECTED) == (oerr_q != ERR_NONE)))
    else $error("status and error code disagree");

  // A held result is kept while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ch.ready) |=> (ovalid_q && $stable(ev_q) && $stable(num_q)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
